FILE: src/sfd_pkg.sv
// Shared types and constants for the signed frame deframer.
// Holds event codes, register indexes and the structs passed between modules.
// No dependencies.
`default_nettype none

package sfd_pkg;

    localparam int unsigned HeaderBytes = 6;
    localparam int unsigned FooterBytes = 2;
    localparam int unsigned PosWidth    = 17;
    localparam int unsigned WordWidth   = 16;
    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned CfgIdxWidth = 2;

    localparam logic [WordWidth-1:0] MaxLenReset = 16'd2048;

    typedef enum logic [2:0] {
        EV_PAYLOAD      = 3'd0,
        EV_COMPLETE     = 3'd1,
        EV_BAD_HDR_SYNC = 3'd2,
        EV_TOO_LONG     = 3'd3,
        EV_BAD_FOOTER   = 3'd4
    } event_code_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_HEADER_SYNC = 2'd0,
        REG_FOOTER_SYNC = 2'd1,
        REG_MAX_LENGTH  = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [WordWidth-1:0] header_sync;
        logic [WordWidth-1:0] footer_sync;
        logic [WordWidth-1:0] max_length;
    } sfd_cfg_t;

    typedef struct packed {
        logic                 valid;
        event_code_t          code;
        logic [ByteWidth-1:0] payload;
        logic [WordWidth-1:0] protocol;
        logic [WordWidth-1:0] length;
    } sfd_result_t;

endpackage

`default_nettype wire

FILE: src/sfd_cfg_regs.sv
// Configuration register bank for the frame deframer.
// Depends on sfd_pkg for register indexes and the config struct.
`default_nettype none

module sfd_cfg_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [sfd_pkg::CfgIdxWidth-1:0]     cfg_index,
    input  wire logic [sfd_pkg::WordWidth-1:0]       cfg_wdata,
    output sfd_pkg::sfd_cfg_t                        cfg
);

    sfd_pkg::sfd_cfg_t cfg_reg;
    sfd_pkg::sfd_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                sfd_pkg::REG_HEADER_SYNC: cfg_next.header_sync = cfg_wdata;
                sfd_pkg::REG_FOOTER_SYNC: cfg_next.footer_sync = cfg_wdata;
                sfd_pkg::REG_MAX_LENGTH:  cfg_next.max_length  = cfg_wdata;
                default:                  cfg_next = cfg_reg; // unknown index: drop
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_sync <= '0;
            cfg_reg.footer_sync <= '0;
            cfg_reg.max_length  <= sfd_pkg::MaxLenReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: src/sfd_in_stage.sv
// Input register stage: holds one accepted byte until the core consumes it.
// Depends on sfd_pkg for widths.
`default_nettype none

module sfd_in_stage (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [sfd_pkg::ByteWidth-1:0]     s_axis_tdata,
    input  wire logic                              advance,
    output logic                                   in_valid,
    output logic [sfd_pkg::ByteWidth-1:0]          in_byte
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [sfd_pkg::ByteWidth-1:0] byte_reg;
    logic                          take;

    // room when empty, or when the held beat leaves this cycle
    assign s_axis_tready = !valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            byte_reg <= s_axis_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

endmodule

`default_nettype wire

FILE: src/sfd_frame_core.sv
// Frame tracking core: position counter, header/footer gathering and checks.
// Depends on sfd_pkg for codes, config and result structs.
`default_nettype none

module sfd_frame_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              step,
    input  wire logic [sfd_pkg::ByteWidth-1:0]     data_byte,
    input  wire sfd_pkg::sfd_cfg_t                 cfg,
    output sfd_pkg::sfd_result_t                   result
);

    localparam logic [sfd_pkg::PosWidth-1:0] HdrBytes = sfd_pkg::PosWidth'(sfd_pkg::HeaderBytes);

    logic [sfd_pkg::PosWidth-1:0]  pos_reg, pos_next;
    logic [sfd_pkg::WordWidth-1:0] sync_reg, sync_next;
    logic [sfd_pkg::WordWidth-1:0] proto_reg, proto_next;
    logic [sfd_pkg::WordWidth-1:0] len_reg, len_next;
    logic [sfd_pkg::WordWidth-1:0] footer_reg, footer_next;
    logic [sfd_pkg::PosWidth-1:0]  payload_end;
    logic [sfd_pkg::PosWidth-1:0]  pos_inc;

    assign payload_end = HdrBytes + sfd_pkg::PosWidth'(len_reg);
    assign pos_inc     = pos_reg + 1'b1;

    always_comb begin
        pos_next    = pos_reg;
        sync_next   = sync_reg;
        proto_next  = proto_reg;
        len_next    = len_reg;
        footer_next = footer_reg;
        result      = '0;
        result.code = sfd_pkg::EV_PAYLOAD;

        if (pos_reg < HdrBytes) begin
            // header: shift into the field that owns this position
            priority if (pos_reg[2:0] < 3'd2) begin
                sync_next = {sync_reg[7:0], data_byte};
            end else if (pos_reg[2:0] < 3'd4) begin
                proto_next = {proto_reg[7:0], data_byte};
            end else begin
                len_next = {len_reg[7:0], data_byte};
            end
            pos_next = pos_inc;
            if (pos_inc == HdrBytes) begin
                priority if (sync_next != cfg.header_sync) begin
                    pos_next     = '0;
                    result.valid = 1'b1;
                    result.code  = sfd_pkg::EV_BAD_HDR_SYNC;
                end else if (len_next > cfg.max_length) begin
                    pos_next     = '0;
                    result.valid = 1'b1;
                    result.code  = sfd_pkg::EV_TOO_LONG;
                end else begin
                    result.valid = 1'b0;
                end
            end
        end else if (pos_reg < payload_end) begin
            pos_next       = pos_inc;
            result.valid   = 1'b1;
            result.code    = sfd_pkg::EV_PAYLOAD;
            result.payload = data_byte;
        end else begin
            footer_next = {footer_reg[7:0], data_byte};
            if (pos_reg == payload_end) begin
                pos_next = pos_inc;
            end else begin
                // last footer byte closes the frame either way
                pos_next     = '0;
                result.valid = 1'b1;
                if (footer_next != cfg.footer_sync) begin
                    result.code = sfd_pkg::EV_BAD_FOOTER;
                end else begin
                    result.code     = sfd_pkg::EV_COMPLETE;
                    result.protocol = proto_reg;
                    result.length   = len_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            sync_reg   <= '0;
            proto_reg  <= '0;
            len_reg    <= '0;
            footer_reg <= '0;
        end else if (step) begin
            pos_reg    <= pos_next;
            sync_reg   <= sync_next;
            proto_reg  <= proto_next;
            len_reg    <= len_next;
            footer_reg <= footer_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/sfd_out_stage.sv
// Result register stage driving the master-side stream.
// Depends on sfd_pkg for the result struct and widths.
`default_nettype none

module sfd_out_stage (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    input  wire sfd_pkg::sfd_result_t                result,
    output logic                                     advance,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [2*sfd_pkg::WordWidth+sfd_pkg::ByteWidth-1:0] m_axis_tdata,
    output logic [2:0]                               m_axis_tuser
);

    logic                 valid_reg, valid_next;
    sfd_pkg::sfd_result_t res_reg;
    logic                 load;

    // free when empty or when the held beat is taken this cycle
    assign advance = !valid_reg || m_axis_tready;
    assign load    = in_valid && advance;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = result.valid;
        end else if (m_axis_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = res_reg.code;
    assign m_axis_tdata  = {res_reg.length, res_reg.protocol, res_reg.payload};

endmodule

`default_nettype wire

FILE: src/signed_frame_deframer_unit.sv
// Signed frame deframer: byte stream in, payload bytes and frame events out.
//
// Slave side (s_axis_*): one received byte per beat in tdata[7:0].
// Master side (m_axis_*): one event per beat. tuser[2:0] is the event code
// (payload byte, packet complete, bad header sync, too long, bad footer);
// tdata carries payload value, protocol id and packet length.
// A frame is a six-byte big-endian header (sync, protocol, length), the
// payload and a two-byte footer sync. Each payload byte gives one event, as
// does the frame end or a failed header check; other bytes give no event.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 header
// sync, 1 footer sync, 2 maximum payload length); write only while idle.
// Each byte passes the input register, then its event the result register.
// Throughput: one byte per cycle while m_axis_tready is high, as the position
// update and compare are combinational between the two registers.
// Reset (aresetn low, synchronous): both stages empty, frame position zero,
// sync words zero, maximum length 2048.
// Stall: while m_axis_tready is low a held event stays put; one more byte
// may sit in the input register, then s_axis_tready drops.
`default_nettype none

module signed_frame_deframer_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // slave-side stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    // master-side stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [7:0] payload_value, [23:8] protocol_id,
                                             // [39:24] packet_length
    output logic [2:0]       m_axis_tuser,   // [2:0] event_code
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    sfd_pkg::sfd_cfg_t    cfg;
    sfd_pkg::sfd_result_t result;
    logic                 in_valid;
    logic [7:0]           in_byte;
    logic                 advance;
    logic                 step;

    // the core advances its frame state only when the byte leaves the input stage
    assign step = in_valid && advance;

    sfd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sfd_in_stage u_in (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .in_valid      (in_valid),
        .in_byte       (in_byte)
    );

    sfd_frame_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .data_byte (in_byte),
        .cfg       (cfg),
        .result    (result)
    );

    sfd_out_stage u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (in_valid),
        .result        (result),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // input back-pressure only when both stages are full and the sink stalls
    a_ready_low_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid && m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a full pipeline");

    // a byte held behind a stalled result must not be consumed
    a_hold_behind_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && m_axis_tvalid && !m_axis_tready) |=> in_valid)
        else $error("input byte dropped during output stall");

    // only payload events carry a payload byte
    a_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser != sfd_pkg::EV_PAYLOAD)) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("payload byte on non-payload event");

    // protocol and length only on packet completion
    a_header_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser != sfd_pkg::EV_COMPLETE)) |->
            (m_axis_tdata[39:8] == 32'd0))
        else $error("header fields on non-completion event");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking bench for signed_frame_deframer_unit: byte stream in, frame events out.
// Holds the frame scoreboard class and the top module that drives and watches the block.
// Depends on sfd_pkg for event codes, register indexes and the reset maximum length.
`timescale 1ns / 1ps

typedef struct packed {
    sfd_pkg::event_code_t code;
    logic [7:0]           payload;
    logic [15:0]          protocol;
    logic [15:0]          length;
} frame_event_t;

class frame_scoreboard;
    logic [15:0]  hdr_sync;
    logic [15:0]  ftr_sync;
    logic [15:0]  max_len;
    logic [16:0]  frame_pos;
    logic [15:0]  got_sync;
    logic [15:0]  got_proto;
    logic [15:0]  got_len;
    logic [15:0]  got_footer;
    frame_event_t awaited_q[$];
    int unsigned  errors;
    int unsigned  bytes_in;
    int unsigned  events_out;
    int unsigned  seen_by_code[8];

    function new();
        hdr_sync   = '0;
        ftr_sync   = '0;
        max_len    = sfd_pkg::MaxLenReset;
        frame_pos  = '0;
        got_sync   = '0;
        got_proto  = '0;
        got_len    = '0;
        got_footer = '0;
        errors     = 0;
        bytes_in   = 0;
        events_out = 0;
        foreach (seen_by_code[i]) seen_by_code[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] value);
        case (idx)
            sfd_pkg::REG_HEADER_SYNC: hdr_sync = value;
            sfd_pkg::REG_FOOTER_SYNC: ftr_sync = value;
            sfd_pkg::REG_MAX_LENGTH:  max_len  = value;
            default: ;
        endcase
    endfunction

    function void add_awaited(sfd_pkg::event_code_t code, logic [7:0] payload,
                              logic [15:0] protocol, logic [15:0] length);
        frame_event_t ev;
        ev.code     = code;
        ev.payload  = payload;
        ev.protocol = protocol;
        ev.length   = length;
        awaited_q.push_back(ev);
    endfunction

    // Advance the frame by one accepted byte and queue whatever event it causes.
    function void note_byte(logic [7:0] b);
        int unsigned payload_end;
        bytes_in++;
        if (frame_pos < sfd_pkg::HeaderBytes) begin
            if (frame_pos < 2)
                got_sync = {got_sync[7:0], b};
            else if (frame_pos < 4)
                got_proto = {got_proto[7:0], b};
            else
                got_len = {got_len[7:0], b};
            frame_pos++;
            if (frame_pos == sfd_pkg::HeaderBytes) begin
                if (got_sync != hdr_sync) begin
                    frame_pos = '0;
                    add_awaited(sfd_pkg::EV_BAD_HDR_SYNC, '0, '0, '0);
                end else if (got_len > max_len) begin
                    frame_pos = '0;
                    add_awaited(sfd_pkg::EV_TOO_LONG, '0, '0, '0);
                end
            end
        end else begin
            payload_end = sfd_pkg::HeaderBytes + got_len;
            if (frame_pos < payload_end) begin
                frame_pos++;
                add_awaited(sfd_pkg::EV_PAYLOAD, b, '0, '0);
            end else begin
                got_footer = {got_footer[7:0], b};
                frame_pos++;
                if (frame_pos == payload_end + sfd_pkg::FooterBytes) begin
                    frame_pos = '0;
                    if (got_footer != ftr_sync)
                        add_awaited(sfd_pkg::EV_BAD_FOOTER, '0, '0, '0);
                    else
                        add_awaited(sfd_pkg::EV_COMPLETE, '0, got_proto, got_len);
                end
            end
        end
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    function void check_event(logic [2:0] code, logic [39:0] data);
        frame_event_t want;
        events_out++;
        seen_by_code[code]++;
        if (awaited_q.size() == 0) begin
            $error("event with nothing awaited: event_code %0d, tdata 0x%h", code, data);
            errors++;
        end else begin
            want = awaited_q.pop_front();
            compare_field("event_code", want.code, code);
            compare_field("payload_value", want.payload, data[7:0]);
            compare_field("protocol_id", want.protocol, data[23:8]);
            compare_field("packet_length", want.length, data[39:24]);
        end
    endfunction

    function int unsigned pending();
        return awaited_q.size();
    endfunction
endclass

module testbench;

    localparam int unsigned CycleLimit     = 1000000;
    localparam int unsigned ResetCycles    = 9;
    // Margin for the input and result registers; headers can still be in flight when
    // the last event has come out.
    localparam int unsigned SettleCycles   = 4;
    localparam int unsigned LongHoldCycles = 300;
    localparam int unsigned PhaseBytes     = 350;
    // Index with no register behind it: writes must be ignored.
    localparam logic [1:0]  RegSpare       = 2'd3;

    typedef enum {FR_GOOD, FR_BAD_SYNC, FR_TOO_LONG, FR_BAD_FOOTER, FR_NOISE} frame_kind_t;
    typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        cfg_we        = 1'b0;
    logic [1:0]  cfg_index     = '0;
    logic [15:0] cfg_wdata     = '0;

    int unsigned cycle_count   = 0;
    int unsigned hold_requests = 0;
    int unsigned burst_left    = 0;

    frame_scoreboard sb = new();

    signed_frame_deframer_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // Watchdog: give up if the run hangs.
    initial begin
        wait (cycle_count >= CycleLimit);
        $display("Mismatches found");
        $finish;
    end

    // Check every event beat against the oldest awaited event.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            sb.check_event(m_axis_tuser, m_axis_tdata);
    end

    // Receiver: switch between stall patterns of random length; on request,
    // hold tready low for a long stretch so the block backs up into its input.
    initial begin : receiver
        rx_mode_t    mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned served;
        mode      = RX_FREE;
        mode_left = 0;
        hold_left = 0;
        served    = 0;
        forever begin
            @(negedge aclk);
            if (served != hold_requests) begin
                served    = hold_requests;
                hold_left = LongHoldCycles;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    RX_FREE:   m_axis_tready <= 1'b1;
                    RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) != 0);
                    RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= (mode_left % 3 != 0);
                endcase
            end
        end
    end

    // Offer one byte and hold it until accepted. Bursts of random length,
    // separated by random gaps, some of them zero.
    task send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_axis_tvalid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_byte(b);
    endtask

    // Big-endian: high byte first.
    task send_word(input logic [15:0] w);
        send_byte(w[15:8]);
        send_byte(w[7:0]);
    endtask

    // Drop valid and wait until every awaited event has come out, then let
    // any header bytes still in flight settle.
    task drain_results();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task cfg_write(input logic [1:0] idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.write_reg(idx, value);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task set_registers(input logic [15:0] hdr, input logic [15:0] ftr,
                       input logic [15:0] max_length);
        drain_results();
        cfg_write(sfd_pkg::REG_HEADER_SYNC, hdr);
        cfg_write(sfd_pkg::REG_FOOTER_SYNC, ftr);
        cfg_write(sfd_pkg::REG_MAX_LENGTH, max_length);
    endtask

    // Mostly short payloads; now and then a longer one or exactly the maximum.
    function automatic int unsigned pick_length();
        int unsigned cap;
        int unsigned roll;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return (sb.max_len <= 64) ? sb.max_len : $urandom_range(0, 64);
        cap = (roll == 1) ? 48 : 10;
        if (cap > sb.max_len) cap = sb.max_len;
        return $urandom_range(0, cap);
    endfunction

    task send_frame(input frame_kind_t kind, input int unsigned len);
        logic [15:0] sync_w;
        logic [15:0] foot_w;
        int unsigned n;
        sync_w = sb.hdr_sync;
        foot_w = sb.ftr_sync;
        if (kind == FR_BAD_SYNC)   sync_w = sync_w ^ 16'($urandom_range(1, 65535));
        if (kind == FR_BAD_FOOTER) foot_w = foot_w ^ 16'($urandom_range(1, 65535));
        if (kind == FR_NOISE) begin
            n = $urandom_range(1, 5);
            repeat (n) send_byte(8'($urandom));
            // Realign: keep feeding random bytes until a frame boundary comes round.
            while (sb.frame_pos != 0) send_byte(8'($urandom));
        end else begin
            send_word(sync_w);
            send_word(16'($urandom));
            send_word(len[15:0]);
            if (kind == FR_GOOD || kind == FR_BAD_FOOTER) begin
                repeat (len) send_byte(8'($urandom));
                send_word(foot_w);
            end
        end
    endtask

    task run_phase(input int unsigned budget);
        int unsigned start;
        int unsigned roll;
        int unsigned len;
        frame_kind_t kind;
        start = sb.bytes_in;
        while (sb.bytes_in - start < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 60)      kind = FR_GOOD;
            else if (roll < 70) kind = FR_BAD_FOOTER;
            else if (roll < 80) kind = FR_BAD_SYNC;
            else if (roll < 88) kind = FR_TOO_LONG;
            else                kind = FR_NOISE;
            // Nothing can exceed the top length, so swap for a bad signature.
            if (kind == FR_TOO_LONG && sb.max_len == 16'hFFFF) kind = FR_BAD_SYNC;
            if (kind == FR_TOO_LONG)
                len = ($urandom_range(0, 1) != 0) ? sb.max_len + 1
                                                  : $urandom_range(sb.max_len + 1, 65535);
            else
                len = pick_length();
            send_frame(kind, len);
        end
    endtask

    initial begin
        repeat (ResetCycles) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset values: zero signatures, maximum 2048. Empty payload, top protocol id.
        send_word(16'h0000);
        send_word(16'hFFFF);
        send_word(16'h0000);
        send_word(16'h0000);
        drain_results();

        cfg_write(sfd_pkg::REG_HEADER_SYNC, 16'hC33C);
        cfg_write(sfd_pkg::REG_FOOTER_SYNC, 16'h3CC3);
        cfg_write(sfd_pkg::REG_MAX_LENGTH, 16'd16);
        // Unused index: must leave the maximum length alone.
        cfg_write(RegSpare, 16'hFFFF);

        // Wrong header signature, off by one bit.
        send_word(16'hC33D);
        send_word(16'h1234);
        send_word(16'h0005);
        // Length one past the maximum.
        send_word(16'hC33C);
        send_word(16'h0000);
        send_word(16'd17);
        // Two payload bytes at both extremes, then a wrong footer.
        send_word(16'hC33C);
        send_word(16'h8001);
        send_word(16'h0002);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_word(16'h3CC2);

        // Random signatures, moderate maximum; open with a long receiver hold-off
        // while a long frame is offered, so the block backs up.
        set_registers(16'($urandom), 16'($urandom), 16'd64);
        hold_requests++;
        send_frame(FR_GOOD, 40);
        run_phase(PhaseBytes);

        // Extremes: all-ones header signature, zero footer, nothing but empty payloads.
        set_registers(16'hFFFF, 16'h0000, 16'd0);
        run_phase(PhaseBytes);

        // Opposite extremes: zero header signature, all-ones footer, top maximum.
        set_registers(16'h0000, 16'hFFFF, 16'hFFFF);
        run_phase(PhaseBytes);

        set_registers(16'($urandom), 16'($urandom), 16'($urandom_range(1, 40)));
        run_phase(PhaseBytes);

        drain_results();
        repeat (2 * SettleCycles) @(posedge aclk);

        $display("Covered %0d input beats and %0d event beats over six register settings.",
                 sb.bytes_in, sb.events_out);
        $display("Events: payload %0d, complete %0d, bad header %0d, too long %0d, bad footer %0d",
                 sb.seen_by_code[sfd_pkg::EV_PAYLOAD], sb.seen_by_code[sfd_pkg::EV_COMPLETE],
                 sb.seen_by_code[sfd_pkg::EV_BAD_HDR_SYNC],
                 sb.seen_by_code[sfd_pkg::EV_TOO_LONG],
                 sb.seen_by_code[sfd_pkg::EV_BAD_FOOTER]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
